// ===== src/keypad_code_lock_controller_core_macros.svh =====
// Assertion macros shared by the keypad code lock controller
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_CORE_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define KCLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kclc: same-cycle check failed");

// next-cycle implication, disabled during reset
`define KCLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kclc: next-cycle check failed");

`endif

// ===== src/kclc_pkg.sv =====
// Types and constants of the keypad code lock controller
`timescale 1ns / 1ps
package kclc_pkg;

  typedef enum logic [2:0] {
    MODE_SET_CODE,
    MODE_ENTER,
    MODE_MENU,
    MODE_WAIT_OPEN,
    MODE_WAIT_CLOSE
  } mode_t;

  typedef enum logic [1:0] {
    PURP_MAIN,
    PURP_OPEN,
    PURP_CHANGE
  } purpose_t;

  localparam logic [7:0] CMD_NONE      = 8'h00;
  localparam logic [7:0] CMD_BUZZER    = 8'h01;
  localparam logic [7:0] CMD_MOTOR_CW  = 8'h02;
  localparam logic [7:0] CMD_MOTOR_CCW = 8'h03;

  localparam logic [2:0] SCR_NONE    = 3'd0;
  localparam logic [2:0] SCR_NEW     = 3'd1;
  localparam logic [2:0] SCR_ENTER   = 3'd2;
  localparam logic [2:0] SCR_MENU    = 3'd3;
  localparam logic [2:0] SCR_OPENING = 3'd4;
  localparam logic [2:0] SCR_CLOSING = 3'd5;

  localparam logic [7:0] KEY_PLUS    = 8'h2B;
  localparam logic [7:0] KEY_MINUS   = 8'h2D;
  localparam logic [7:0] DIGIT_RESET = 8'h37;

  localparam logic [2:0] LIMIT_RESET = 3'd3;
  localparam logic [7:0] DONE_RESET  = 8'h04;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_LINK = 1'b1;

  localparam logic CFG_MAX_WRONG = 1'b0;
  localparam logic CFG_DONE_CODE = 1'b1;

  typedef struct packed {
    mode_t      mode;
    purpose_t   purpose;
    logic [2:0] attempt;
  } ctrl_t;

  typedef struct packed {
    logic       link_send;
    logic [7:0] link_command;
    logic [2:0] screen;
    logic       echo_star;
  } res_t;

endpackage

// ===== src/kclc_step.sv =====
// Next-state and result logic for one keypad or link transaction
`timescale 1ns / 1ps
module kclc_step import kclc_pkg::*; #(
  parameter int CODE_DIGITS = 5,
  parameter int IDX_W       = 3
) (
  input  ctrl_t            ctrl,
  input  logic [IDX_W-1:0] idx,
  input  logic [2:0]       max_wrong,
  input  logic [7:0]       done_code,
  input  logic [7:0]       stored [CODE_DIGITS],
  input  logic [7:0]       entered [CODE_DIGITS],
  input  logic             op,
  input  logic [7:0]       key,
  input  logic [7:0]       link_byte,
  output ctrl_t            ctrl_nxt,
  output logic [IDX_W-1:0] idx_nxt,
  output logic [IDX_W-1:0] wr_idx,
  output logic             wr_stored,
  output logic             wr_entered,
  output res_t             res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_DIGITS - 1);

  logic [IDX_W-1:0] idx_eff;
  logic             last;
  logic             match;
  logic             key_ev;
  logic             done_ev;
  logic [2:0]       limit;
  logic             at_limit;

  assign idx_eff  = (32'(idx) >= CODE_DIGITS) ? '0 : idx;
  assign last     = (idx_eff == LAST_IDX);
  assign key_ev   = (op == OP_KEY);
  assign done_ev  = (op == OP_LINK) && (link_byte == done_code);
  assign limit    = (max_wrong == 3'd0) ? 3'd1 : max_wrong;
  assign at_limit = (ctrl.attempt == limit);
  assign wr_idx   = idx_eff;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (IDX_W'(i) == idx_eff) begin
        match = match & (key == stored[i]);
      end else begin
        match = match & (entered[i] == stored[i]);
      end
    end
  end

  // next state
  always_comb begin
    ctrl_nxt   = ctrl;
    idx_nxt    = idx;
    wr_stored  = 1'b0;
    wr_entered = 1'b0;
    unique case (ctrl.mode)
      MODE_SET_CODE, MODE_ENTER: begin
        if (key_ev) begin
          wr_stored  = (ctrl.mode == MODE_SET_CODE);
          wr_entered = (ctrl.mode == MODE_ENTER);
          idx_nxt    = last ? '0 : idx_eff + 1'b1;
          if (last) begin
            if (ctrl.mode == MODE_SET_CODE) begin
              ctrl_nxt.mode    = MODE_ENTER;
              ctrl_nxt.purpose = PURP_MAIN;
              ctrl_nxt.attempt = 3'd1;
            end else if (match) begin
              unique case (ctrl.purpose)
                PURP_OPEN:   ctrl_nxt.mode = MODE_WAIT_OPEN;
                PURP_CHANGE: ctrl_nxt.mode = MODE_SET_CODE;
                default:     ctrl_nxt.mode = MODE_MENU;
              endcase
            end else begin
              ctrl_nxt.attempt = at_limit ? 3'd1 : ctrl.attempt + 3'd1;
            end
          end
        end
      end
      MODE_MENU: begin
        if (key_ev && (key == KEY_PLUS || key == KEY_MINUS)) begin
          ctrl_nxt.mode    = MODE_ENTER;
          ctrl_nxt.purpose = (key == KEY_PLUS) ? PURP_OPEN : PURP_CHANGE;
          ctrl_nxt.attempt = 3'd1;
          idx_nxt          = '0;
        end
      end
      MODE_WAIT_OPEN: begin
        if (done_ev) begin
          ctrl_nxt.mode = MODE_WAIT_CLOSE;
        end
      end
      MODE_WAIT_CLOSE: begin
        if (done_ev) begin
          ctrl_nxt.mode    = MODE_ENTER;
          ctrl_nxt.purpose = PURP_MAIN;
          ctrl_nxt.attempt = 3'd1;
          idx_nxt          = '0;
        end
      end
      default: ctrl_nxt = ctrl;
    endcase
  end

  // result
  always_comb begin
    res = '{link_send: 1'b0, link_command: CMD_NONE, screen: SCR_NONE, echo_star: 1'b0};
    unique case (ctrl.mode)
      MODE_SET_CODE, MODE_ENTER: begin
        if (key_ev) begin
          res.echo_star = 1'b1;
          if (last) begin
            if (ctrl.mode == MODE_SET_CODE) begin
              res.screen = SCR_ENTER;
            end else if (match) begin
              unique case (ctrl.purpose)
                PURP_OPEN: begin
                  res.link_send    = 1'b1;
                  res.link_command = CMD_MOTOR_CW;
                  res.screen       = SCR_OPENING;
                end
                PURP_CHANGE: res.screen = SCR_NEW;
                default:     res.screen = SCR_MENU;
              endcase
            end else begin
              res.screen = SCR_ENTER;
              if (at_limit) begin
                res.link_send    = 1'b1;
                res.link_command = CMD_BUZZER;
              end
            end
          end
        end
      end
      MODE_MENU: begin
        if (key_ev && (key == KEY_PLUS || key == KEY_MINUS)) begin
          res.screen = SCR_ENTER;
        end
      end
      MODE_WAIT_OPEN: begin
        if (done_ev) begin
          res.link_send    = 1'b1;
          res.link_command = CMD_MOTOR_CCW;
          res.screen       = SCR_CLOSING;
        end
      end
      MODE_WAIT_CLOSE: begin
        if (done_ev) begin
          res.screen = SCR_ENTER;
        end
      end
      default: res.screen = SCR_NONE;
    endcase
  end

endmodule

// ===== src/keypad_code_lock_controller_core.sv =====
// Top level of the keypad code lock controller
// Usage:
//   Input stream in_*: one transaction per keypad key press (in_tuser = 0)
//   or per byte received from the motor link (in_tuser = 1). in_tdata holds
//   the key code in bits 7:0 and the link byte in bits 15:8.
//   Result stream out_*: exactly one transaction per input transaction.
//   out_tuser flags a command byte to send; out_tdata holds the command,
//   the screen code and the echo-star flag.
//   Configuration: cfg_we with cfg_addr 0 writes the wrong-attempt limit,
//   cfg_addr 1 writes the motor done byte; write only while idle.
// Timing:
//   The result is valid in the cycle after the input transaction. Throughput is
//   one transaction per cycle while out_tready is high: the next state and the
//   result are formed in a single pass of logic into the state and output registers.
// Reset:
//   rst_n low returns the lock to code-setting mode with every code digit
//   at '7', the limit at 3 and the done byte at 0x04; no result is pending.
// Stall:
//   While a result waits with out_tready low, in_tready drops; a new
//   transaction is taken in the same cycle that the pending result leaves.
`timescale 1ns / 1ps
`include "keypad_code_lock_controller_core_macros.svh"
module keypad_code_lock_controller_core import kclc_pkg::*; #(
  parameter int CODE_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] key_code, [15:8] link_byte
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] link_command, [10:8] screen, [11] echo_star
  output logic        out_tuser,  // [0] link_send
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  ctrl_t            ctrl_r;
  ctrl_t            ctrl_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_stored;
  logic             wr_entered;
  logic [7:0]       stored_r [CODE_DIGITS];
  logic [7:0]       entered_r [CODE_DIGITS];
  logic [2:0]       max_wrong_r;
  logic [7:0]       done_code_r;
  res_t             res;
  res_t             res_r;
  logic             out_valid_r;
  logic             in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  kclc_step #(
    .CODE_DIGITS (CODE_DIGITS),
    .IDX_W       (IDX_W)
  ) u_step (
    .ctrl       (ctrl_r),
    .idx        (idx_r),
    .max_wrong  (max_wrong_r),
    .done_code  (done_code_r),
    .stored     (stored_r),
    .entered    (entered_r),
    .op         (in_tuser),
    .key        (in_tdata[7:0]),
    .link_byte  (in_tdata[15:8]),
    .ctrl_nxt   (ctrl_nxt),
    .idx_nxt    (idx_nxt),
    .wr_idx     (wr_idx),
    .wr_stored  (wr_stored),
    .wr_entered (wr_entered),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_wrong_r <= LIMIT_RESET;
      done_code_r <= DONE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_WRONG: max_wrong_r <= cfg_wdata[2:0];
        CFG_DONE_CODE: done_code_r <= cfg_wdata;
        default:       done_code_r <= done_code_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '{mode: MODE_SET_CODE, purpose: PURP_MAIN, attempt: 3'd1};
      idx_r  <= '0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_r[i]  <= DIGIT_RESET;
        entered_r[i] <= DIGIT_RESET;
      end
    end else if (in_fire) begin
      ctrl_r <= ctrl_nxt;
      idx_r  <= idx_nxt;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (IDX_W'(i) == wr_idx) begin
          if (wr_stored) begin
            stored_r[i] <= in_tdata[7:0];
          end
          if (wr_entered) begin
            entered_r[i] <= in_tdata[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.link_send;
  assign out_tdata  = {4'b0000, res_r.echo_star, res_r.screen, res_r.link_command};

  `KCLC_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid_r)
  `KCLC_ASSERT_NOW(a_send_has_cmd, clk, rst_n, out_valid_r,
    res_r.link_send == (res_r.link_command != CMD_NONE))
  `KCLC_ASSERT_NOW(a_idx_idle, clk, rst_n,
    ctrl_r.mode == MODE_MENU || ctrl_r.mode == MODE_WAIT_OPEN ||
    ctrl_r.mode == MODE_WAIT_CLOSE, idx_r == '0)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the keypad code lock controller core
`timescale 1ns / 1ps
module tb;
  import kclc_pkg::*;

  localparam int NDIG        = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic [7:0]  cfg_wdata  = '0;

  keypad_code_lock_controller_core #(.CODE_DIGITS(NDIG)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // lock model state
  mode_t                  m_mode;
  purpose_t               m_purpose;
  int                     m_idx;
  logic [2:0]             m_attempt;
  logic [NDIG-1:0][7:0]   m_stored;
  logic [NDIG-1:0][7:0]   m_entered;
  logic [2:0]             m_lim;
  logic [7:0]             m_done;

  res_t result_q[$];
  int   err_cnt      = 0;
  int   events_sent  = 0;
  int   results_seen = 0;
  int   buzz_cnt     = 0;
  int   door_cnt     = 0;
  int   cycle_cnt    = 0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   good_pct      = 60;
  bit   hold_req      = 1'b0;
  int   hold_left     = 0;
  bit   plan_good     = 1'b1;
  int   plan_bad_pos  = 0;

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  function automatic void reset_lock_model();
    m_mode    = MODE_SET_CODE;
    m_purpose = PURP_MAIN;
    m_idx     = 0;
    m_attempt = 3'd1;
    m_stored  = {NDIG{DIGIT_RESET}};
    m_entered = {NDIG{DIGIT_RESET}};
    m_lim     = LIMIT_RESET;
    m_done    = DONE_RESET;
  endfunction

  function automatic void start_request(purpose_t why);
    m_mode    = MODE_ENTER;
    m_purpose = why;
    m_idx     = 0;
    m_attempt = 3'd1;
  endfunction

  function automatic res_t lock_step(logic op, logic [7:0] key, logic [7:0] lbyte);
    res_t       r;
    bit         last;
    logic [2:0] lim;
    r = '0;
    if (op == OP_KEY && (m_mode == MODE_SET_CODE || m_mode == MODE_ENTER)) begin
      if (m_idx >= NDIG) m_idx = 0;
      if (m_mode == MODE_SET_CODE) m_stored[m_idx] = key;
      else m_entered[m_idx] = key;
      r.echo_star = 1'b1;
      last = (m_idx + 1 >= NDIG);
      m_idx = last ? 0 : m_idx + 1;
      if (last) begin
        if (m_mode == MODE_SET_CODE) begin
          start_request(PURP_MAIN);
          r.screen = SCR_ENTER;
        end else if (m_stored == m_entered) begin
          if (m_purpose == PURP_OPEN) begin
            m_mode         = MODE_WAIT_OPEN;
            r.link_send    = 1'b1;
            r.link_command = CMD_MOTOR_CW;
            r.screen       = SCR_OPENING;
          end else if (m_purpose == PURP_CHANGE) begin
            m_mode   = MODE_SET_CODE;
            r.screen = SCR_NEW;
          end else begin
            m_mode   = MODE_MENU;
            r.screen = SCR_MENU;
          end
        end else begin
          lim = (m_lim == 3'd0) ? 3'd1 : m_lim;
          r.screen = SCR_ENTER;
          if (m_attempt == lim) begin
            r.link_send    = 1'b1;
            r.link_command = CMD_BUZZER;
            m_attempt      = 3'd1;
          end else begin
            m_attempt = m_attempt + 3'd1;
          end
        end
      end
    end else if (op == OP_KEY && m_mode == MODE_MENU) begin
      if (key == KEY_PLUS) begin
        start_request(PURP_OPEN);
        r.screen = SCR_ENTER;
      end else if (key == KEY_MINUS) begin
        start_request(PURP_CHANGE);
        r.screen = SCR_ENTER;
      end
    end else if (op == OP_LINK && lbyte == m_done) begin
      if (m_mode == MODE_WAIT_OPEN) begin
        m_mode         = MODE_WAIT_CLOSE;
        r.link_send    = 1'b1;
        r.link_command = CMD_MOTOR_CCW;
        r.screen       = SCR_CLOSING;
      end else if (m_mode == MODE_WAIT_CLOSE) begin
        start_request(PURP_MAIN);
        r.screen = SCR_ENTER;
      end
    end
    return r;
  endfunction

  // choose a plausible next event from the current lock state
  function automatic void pick_event(output logic op, output logic [7:0] key,
                                     output logic [7:0] lbyte);
    int r;
    op    = OP_KEY;
    key   = rnd8();
    lbyte = rnd8();
    r     = $urandom_range(99);
    case (m_mode)
      MODE_SET_CODE: begin
        if (r < 6) op = OP_LINK;
      end
      MODE_ENTER: begin
        if (m_idx == 0) begin
          plan_good    = ($urandom_range(99) < good_pct);
          plan_bad_pos = $urandom_range(NDIG - 1);
        end
        if (r < 6) op = OP_LINK;
        else if (plan_good || m_idx != plan_bad_pos) key = m_stored[m_idx];
        else key = m_stored[m_idx] ^ 8'($urandom_range(254) + 1);
      end
      MODE_MENU: begin
        if (r < 40) key = KEY_PLUS;
        else if (r < 75) key = KEY_MINUS;
        else if (r < 88) op = OP_LINK;
      end
      MODE_WAIT_OPEN, MODE_WAIT_CLOSE: begin
        if (r < 70) begin
          op    = OP_LINK;
          lbyte = m_done;
        end else if (r < 85) begin
          op = OP_LINK;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string fld, int want, int got);
    $display("tb: mismatch in %s at result %0d: want 0x%0h got 0x%0h",
             fld, results_seen, want, got);
    err_cnt++;
  endtask

  // check results, then predict for the transaction accepted at this edge
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", 0, out_tdata);
        end else begin
          want = result_q.pop_front();
          if (out_tuser !== want.link_send)
            report_mismatch("link_send", want.link_send, out_tuser);
          if (out_tdata[7:0] !== want.link_command)
            report_mismatch("link_command", want.link_command, out_tdata[7:0]);
          if (out_tdata[10:8] !== want.screen)
            report_mismatch("screen", want.screen, out_tdata[10:8]);
          if (out_tdata[11] !== want.echo_star)
            report_mismatch("echo_star", want.echo_star, out_tdata[11]);
          if (out_tdata[15:12] !== 4'h0)
            report_mismatch("tdata padding", 0, out_tdata[15:12]);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        want = lock_step(in_tuser, in_tdata[7:0], in_tdata[15:8]);
        if (want.link_command == CMD_BUZZER) buzz_cnt++;
        if (want.link_command == CMD_MOTOR_CCW) door_cnt++;
        result_q.push_back(want);
        events_sent++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles", cycle_cnt);
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_event(bit auto_pick, logic op, logic [7:0] key, logic [7:0] lbyte);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    if (auto_pick) pick_event(op, key, lbyte);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {lbyte, key};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_config(logic [2:0] lim, logic [7:0] done_byte);
    logic [7:0] lim_word;
    lim_word      = rnd8();
    lim_word[2:0] = lim;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_MAX_WRONG;
    cfg_wdata <= lim_word;
    m_lim      = lim;
    @(negedge clk);
    cfg_addr  <= CFG_DONE_CODE;
    cfg_wdata <= done_byte;
    m_done     = done_byte;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(logic [2:0] lim, logic [7:0] done_byte, int good, int count);
    drain();
    write_config(lim, done_byte);
    good_pct = good;
    repeat (count) send_event(1'b1, OP_KEY, 8'h00, 8'h00);
  endtask

  task automatic test_set_and_open();
    logic [NDIG-1:0][7:0] code;
    code = {8'h80, KEY_MINUS, KEY_PLUS, 8'hFF, 8'h00};
    send_idle_pct = 32;
    recv_idle_pct = 64;
    send_event(1'b0, OP_LINK, rnd8(), DONE_RESET);
    for (int i = 0; i < NDIG; i++) send_event(1'b0, OP_KEY, code[i], rnd8());
    for (int i = 0; i < NDIG; i++) send_event(1'b0, OP_KEY, code[i], rnd8());
    send_event(1'b0, OP_KEY, 8'h78, rnd8());
    send_event(1'b0, OP_LINK, rnd8(), DONE_RESET);
    send_event(1'b0, OP_KEY, KEY_PLUS, rnd8());
    for (int i = 0; i < NDIG; i++) send_event(1'b0, OP_KEY, code[i], rnd8());
    send_event(1'b0, OP_KEY, DONE_RESET, rnd8());
    send_event(1'b0, OP_LINK, rnd8(), 8'hFF);
    send_event(1'b0, OP_LINK, rnd8(), DONE_RESET);
    send_event(1'b0, OP_LINK, rnd8(), DONE_RESET);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 32;
    recv_idle_pct = 64;
    run_phase(3'd1, 8'h00, 60, 220);
    run_phase(3'd7, 8'hFF, 15, 220);
  endtask

  task automatic test_receiver_gaps();
    send_idle_pct = 64;
    recv_idle_pct = 32;
    run_phase(3'd0, rnd8(), 50, 220);
    run_phase(3'd5, KEY_PLUS, 40, 220);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(LIMIT_RESET, DONE_RESET, 55, 220);
    run_phase(3'd2, rnd8(), 65, 200);
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    hold_req = 1'b1;
    repeat (30) send_event(1'b1, OP_KEY, 8'h00, 8'h00);
  endtask

  initial begin
    reset_lock_model();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_set_and_open();
    test_sender_gaps();
    test_receiver_gaps();
    test_output_holdoff();
    test_full_rate();
    drain();
    repeat (4) @(posedge clk);
    $display("tb: %0d events sent, %0d results checked, %0d buzzer, %0d door cycles",
             events_sent, results_seen, buzz_cnt, door_cnt);
    $display("tb: limits 0 to 7, done bytes 0x00 and 0xFF, three idle mixes, one long stall");
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
